// ===== design/nrlm_pkg.sv =====
package nrlm_pkg;

	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_EPS   = 2'd1;
	localparam logic [1:0] KIND_CLASS = 2'd2;
	localparam logic [1:0] KIND_TERM  = 2'd3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CHAR = 1'b1;

	localparam logic CFG_START = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	localparam logic [7:0] CHAR_LF = 8'h0A;

	// One NFA entry as it sits in the table memory.
	typedef struct packed {
		logic [127:0] cls;
		logic         accepting;
		logic         alt_valid;
		logic [9:0]   alt_index;
		logic         next_valid;
		logic [9:0]   next_index;
		logic [7:0]   edge_char;
		logic [1:0]   kind;
	} nfa_entry_t;

endpackage

// ===== design/nfa_regex_line_matcher_unit.sv =====
// Thompson NFA line matcher. A load word (command 0) writes one NFA entry and
// answers in the cycle after it is accepted. A character word takes time set
// by the work on the state memories: for each member of the active set the
// move fetches its entry, tests its edge when its index is below state_count
// and marks a new successor; then each member of the new set goes through the
// epsilon closure and the clearing of its marks, with further steps to mark
// the successors of each epsilon entry. After a reset, a load, a register
// write, a match or a restart the start closure is rebuilt first, at the same
// cost per member. Every memory read is registered, so each set member costs
// several sequencer steps. After reset the mark memory is cleared entry by
// entry, with busy high. Each result appears for exactly one cycle with done
// high; the receiver cannot hold it off, and every word gives exactly one
// result.
module nfa_regex_line_matcher_unit #(
	parameter int NFA_STATES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic          command,
	input  logic [7:0]    char_code,
	input  logic [9:0]    entry_index,
	input  logic [1:0]    edge_kind,
	input  logic [9:0]    next_index,
	input  logic          next_valid,
	input  logic [9:0]    alt_index,
	input  logic          alt_valid,
	input  logic          accepting,
	input  logic [63:0]   class_low,
	input  logic [63:0]   class_high,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [10:0]   cfg_data,
	output logic          done,
	output logic          matched,
	output logic [9:0]    match_state,
	output logic          restarted,
	output logic          skipping
);

	localparam int IW = $clog2(NFA_STATES);
	localparam int CW = $clog2(NFA_STATES + 1);
	localparam logic [IW-1:0] LastIdx = IW'(NFA_STATES - 1);

	typedef enum logic [16:0] {
		ST_INIT     = 17'b00000000000000001,
		ST_IDLE     = 17'b00000000000000010,
		ST_CHAR     = 17'b00000000000000100,
		ST_MV_FETCH = 17'b00000000000001000,
		ST_MV_EDGE  = 17'b00000000000010000,
		ST_MV_HIT   = 17'b00000000000100000,
		ST_MV_END   = 17'b00000000001000000,
		ST_M0R      = 17'b00000000010000000,
		ST_M0W      = 17'b00000000100000000,
		ST_M1R      = 17'b00000001000000000,
		ST_M1W      = 17'b00000010000000000,
		ST_C_FETCH  = 17'b00000100000000000,
		ST_C_EDGE   = 17'b00001000000000000,
		ST_C_SUCC   = 17'b00010000000000000,
		ST_CLR_RD   = 17'b00100000000000000,
		ST_CLR_WR   = 17'b01000000000000000,
		ST_FIN      = 17'b10000000000000000
	} state_t;

	state_t state_q, ret0_q;

	// Table memory, mark memory and the two set lists (bank select in the MSB).
	nrlm_pkg::nfa_entry_t nfa_mem [NFA_STATES];
	logic                 mark_mem [NFA_STATES];
	logic [IW-1:0]        list_mem [2*NFA_STATES];

	nrlm_pkg::nfa_entry_t nfa_rd_q, nfa_wdata;
	logic                 mark_rd_q;
	logic [IW-1:0]        list_rd_q;

	logic                 nfa_we;
	logic [IW-1:0]        nfa_raddr;
	logic                 mark_we, mark_wdata;
	logic [IW-1:0]        mark_waddr, mark_raddr;
	logic                 list_we;
	logic [IW:0]          list_waddr, list_raddr;
	logic [IW-1:0]        list_wdata;

	logic [9:0]    start_index_q;
	logic [10:0]   state_count_q;
	logic          line_done_q, pending_q, seeding_q, act_sel_q;
	logic [CW-1:0] ptr_q, new_len_q, act_len_q;
	logic [IW-1:0] t0_q, t1_q, s_q, best_q;
	logic          v0_q, v1_q, best_v_q;
	logic [7:0]    char_q;

	logic          accept_item;
	logic          hit;
	logic          new_mark;

	assign busy        = (state_q != ST_IDLE);
	assign accept_item = start && !busy;
	assign new_mark    = !mark_rd_q;

	assign nfa_wdata.cls        = {class_high, class_low};
	assign nfa_wdata.accepting  = accepting;
	assign nfa_wdata.alt_valid  = alt_valid;
	assign nfa_wdata.alt_index  = alt_index;
	assign nfa_wdata.next_valid = next_valid;
	assign nfa_wdata.next_index = next_index;
	assign nfa_wdata.edge_char  = char_code;
	assign nfa_wdata.kind       = edge_kind;

	// Characters 128 and up never belong to a class.
	always_comb begin
		hit = 1'b0;
		case (nfa_rd_q.kind)
			nrlm_pkg::KIND_CHAR:  hit = (nfa_rd_q.edge_char == char_q);
			nrlm_pkg::KIND_CLASS: hit = !char_q[7] && nfa_rd_q.cls[char_q[6:0]];
			default:              hit = 1'b0;
		endcase
	end

	always_comb begin
		nfa_we     = accept_item && (command == nrlm_pkg::CMD_LOAD)
			&& (int'(entry_index) < NFA_STATES);
		nfa_raddr  = list_rd_q;
		mark_raddr = (state_q == ST_M1R) ? t1_q : t0_q;
		mark_we    = 1'b0;
		mark_wdata = 1'b0;
		mark_waddr = t0_q;
		list_we    = 1'b0;
		list_wdata = t0_q;
		list_waddr = {~act_sel_q, new_len_q[IW-1:0]};
		list_raddr = {~act_sel_q, ptr_q[IW-1:0]};
		unique case (state_q)
			ST_INIT: begin
				mark_we    = 1'b1;
				mark_waddr = ptr_q[IW-1:0];
			end
			ST_MV_FETCH: list_raddr = {act_sel_q, ptr_q[IW-1:0]};
			ST_M0W: begin
				mark_we    = new_mark;
				mark_wdata = 1'b1;
				list_we    = new_mark;
			end
			ST_M1W: begin
				mark_we    = new_mark;
				mark_wdata = 1'b1;
				mark_waddr = t1_q;
				list_we    = new_mark;
				list_wdata = t1_q;
			end
			ST_CLR_WR: begin
				mark_we    = 1'b1;
				mark_waddr = list_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nfa_we) begin
			nfa_mem[entry_index[IW-1:0]] <= nfa_wdata;
		end
		nfa_rd_q <= nfa_mem[nfa_raddr];
		if (mark_we) begin
			mark_mem[mark_waddr] <= mark_wdata;
		end
		mark_rd_q <= mark_mem[mark_raddr];
		if (list_we) begin
			list_mem[list_waddr] <= list_wdata;
		end
		list_rd_q <= list_mem[list_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			ret0_q        <= ST_IDLE;
			start_index_q <= '0;
			state_count_q <= 11'd1024;
			line_done_q   <= 1'b0;
			pending_q     <= 1'b1;
			seeding_q     <= 1'b0;
			act_sel_q     <= 1'b0;
			ptr_q         <= '0;
			new_len_q     <= '0;
			act_len_q     <= '0;
			t0_q          <= '0;
			t1_q          <= '0;
			v0_q          <= 1'b0;
			v1_q          <= 1'b0;
			s_q           <= '0;
			best_q        <= '0;
			best_v_q      <= 1'b0;
			char_q        <= '0;
			done          <= 1'b0;
			matched       <= 1'b0;
			match_state   <= '0;
			restarted     <= 1'b0;
			skipping      <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					ptr_q <= CW'(ptr_q + 1'b1);
					if (ptr_q[IW-1:0] == LastIdx) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						if (command == nrlm_pkg::CMD_LOAD) begin
							done        <= 1'b1;
							matched     <= 1'b0;
							match_state <= '0;
							restarted   <= 1'b0;
							skipping    <= 1'b0;
							line_done_q <= 1'b0;
							pending_q   <= 1'b1;
						end else begin
							char_q <= char_code;
							if (pending_q) begin
								seeding_q <= 1'b1;
								new_len_q <= '0;
								ptr_q     <= '0;
								best_v_q  <= 1'b0;
								t0_q      <= start_index_q[IW-1:0];
								v0_q      <= (int'(start_index_q) < NFA_STATES);
								ret0_q    <= ST_C_FETCH;
								state_q   <= ST_M0R;
							end else begin
								state_q <= ST_CHAR;
							end
						end
					end
				end
				ST_CHAR: begin
					if (line_done_q) begin
						done        <= 1'b1;
						matched     <= 1'b0;
						match_state <= '0;
						restarted   <= 1'b0;
						skipping    <= 1'b1;
						if (char_q == nrlm_pkg::CHAR_LF) begin
							line_done_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end else begin
						new_len_q <= '0;
						ptr_q     <= '0;
						best_v_q  <= 1'b0;
						state_q   <= ST_MV_FETCH;
					end
				end
				ST_MV_FETCH: begin
					if (ptr_q == act_len_q) begin
						state_q <= ST_MV_END;
					end else begin
						ptr_q   <= CW'(ptr_q + 1'b1);
						state_q <= ST_MV_EDGE;
					end
				end
				ST_MV_EDGE: begin
					if (int'(list_rd_q) < int'(state_count_q)) begin
						state_q <= ST_MV_HIT;
					end else begin
						state_q <= ST_MV_FETCH;
					end
				end
				ST_MV_HIT: begin
					if (hit && nfa_rd_q.next_valid
						&& (int'(nfa_rd_q.next_index) < NFA_STATES)) begin
						t0_q    <= nfa_rd_q.next_index[IW-1:0];
						v0_q    <= 1'b1;
						ret0_q  <= ST_MV_FETCH;
						state_q <= ST_M0R;
					end else begin
						state_q <= ST_MV_FETCH;
					end
				end
				ST_MV_END: begin
					if (new_len_q == '0) begin
						// Nothing survived: the next character starts over.
						done        <= 1'b1;
						matched     <= 1'b0;
						match_state <= '0;
						restarted   <= 1'b1;
						skipping    <= 1'b0;
						pending_q   <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						ptr_q   <= '0;
						state_q <= ST_C_FETCH;
					end
				end
				ST_M0R: state_q <= v0_q ? ST_M0W : ret0_q;
				ST_M0W: begin
					if (new_mark) begin
						new_len_q <= CW'(new_len_q + 1'b1);
					end
					state_q <= ret0_q;
				end
				ST_M1R: state_q <= v1_q ? ST_M1W : ST_C_FETCH;
				ST_M1W: begin
					if (new_mark) begin
						new_len_q <= CW'(new_len_q + 1'b1);
					end
					state_q <= ST_C_FETCH;
				end
				ST_C_FETCH: begin
					// The new list doubles as the work queue of the closure.
					if (ptr_q == new_len_q) begin
						ptr_q   <= '0;
						state_q <= ST_CLR_RD;
					end else begin
						ptr_q   <= CW'(ptr_q + 1'b1);
						state_q <= ST_C_EDGE;
					end
				end
				ST_C_EDGE: begin
					s_q     <= list_rd_q;
					state_q <= ST_C_SUCC;
				end
				ST_C_SUCC: begin
					if (nfa_rd_q.accepting && (!best_v_q || (s_q < best_q))) begin
						best_v_q <= 1'b1;
						best_q   <= s_q;
					end
					if (nfa_rd_q.kind == nrlm_pkg::KIND_EPS) begin
						t0_q    <= nfa_rd_q.next_index[IW-1:0];
						v0_q    <= nfa_rd_q.next_valid
							&& (int'(nfa_rd_q.next_index) < NFA_STATES);
						t1_q    <= nfa_rd_q.alt_index[IW-1:0];
						v1_q    <= nfa_rd_q.alt_valid
							&& (int'(nfa_rd_q.alt_index) < NFA_STATES);
						ret0_q  <= ST_M1R;
						state_q <= ST_M0R;
					end else begin
						state_q <= ST_C_FETCH;
					end
				end
				ST_CLR_RD: begin
					if (ptr_q == new_len_q) begin
						state_q <= ST_FIN;
					end else begin
						ptr_q   <= CW'(ptr_q + 1'b1);
						state_q <= ST_CLR_WR;
					end
				end
				ST_CLR_WR: state_q <= ST_CLR_RD;
				ST_FIN: begin
					act_sel_q <= ~act_sel_q;
					act_len_q <= new_len_q;
					if (seeding_q) begin
						seeding_q <= 1'b0;
						pending_q <= 1'b0;
						state_q   <= ST_CHAR;
					end else begin
						done        <= 1'b1;
						matched     <= best_v_q;
						match_state <= best_v_q ? 10'(best_q) : '0;
						restarted   <= 1'b0;
						skipping    <= 1'b0;
						if (best_v_q) begin
							line_done_q <= (char_q != nrlm_pkg::CHAR_LF);
							pending_q   <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cfg_we) begin
				case (cfg_index)
					nrlm_pkg::CFG_START: start_index_q <= cfg_data[9:0];
					default:             state_count_q <= cfg_data;
				endcase
				line_done_q <= 1'b0;
				pending_q   <= 1'b1;
			end
		end
	end

endmodule
